/* rtl/core/twam_pkg.sv */
`timescale 1ns / 1ps

package twam_pkg;

   localparam int WINDOW_MAX_DEF   = 64;
   localparam int NUM_AXES         = 3;
   localparam int SAMPLE_W         = 16;
   localparam int CFG_W            = 7;
   localparam int REQ_W            = NUM_AXES * SAMPLE_W;
   localparam int RSP_W            = 3 * NUM_AXES * SAMPLE_W;
   localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(8);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic acc_valid;
      logic acc_first;
      logic div_start;
   } lane_ctl_type;

   typedef struct packed {
      sample_type avg;
      sample_type hi;
      sample_type lo;
   } lane_res_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

endpackage

/* rtl/core/twam_lane.sv */
`timescale 1ns / 1ps

module twam_lane #(
   parameter int LW = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  twam_pkg::lane_ctl_type ctl,
   input  twam_pkg::sample_type  sample,
   input  logic [LW-1:0]         len,
   output logic                  busy,
   output twam_pkg::lane_res_type res
);
   import twam_pkg::*;

   localparam int SW = SAMPLE_W + LW;
   localparam int NW = $clog2(SW + 1);

   logic signed [SW-1:0] sum_ff;
   sample_type           hi_ff;
   sample_type           lo_ff;
   logic [SW-1:0]        quot_ff;
   logic [LW-1:0]        rem_ff;
   logic                 neg_ff;
   logic [NW-1:0]        cnt_ff;
   logic                 busy_ff;

   logic signed [SW-1:0] sum_add;
   logic [SW-1:0]        sum_mag;
   logic [LW:0]          rem_sh;
   logic                 ge;
   logic [SW-1:0]        quot_s;

   always_comb begin
      sum_add = sum_ff + SW'(sample);
      sum_mag = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;
      rem_sh  = {rem_ff, quot_ff[SW-1]};
      ge      = (rem_sh >= {1'b0, len});
      quot_s  = neg_ff ? (~quot_ff + SW'(1)) : quot_ff;
   end

   // accumulate sum and extremes over the scan
   always_ff @(posedge clock) begin
      if (ctl.acc_valid) begin
         if (ctl.acc_first) begin
            sum_ff <= SW'(sample);
            hi_ff  <= sample;
            lo_ff  <= sample;
         end else begin
            sum_ff <= sum_add;
            if (sample > hi_ff) begin
               hi_ff <= sample;
            end
            if (sample < lo_ff) begin
               lo_ff <= sample;
            end
         end
      end
   end

   // restoring divide of the magnitude, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (ctl.div_start) begin
         neg_ff  <= sum_ff[SW-1];
         quot_ff <= sum_mag;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[SW-2:0], ge};
         rem_ff  <= ge ? LW'(rem_sh - {1'b0, len}) : rem_sh[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= NW'(SW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy    = busy_ff;
   assign res.avg = quot_s[SAMPLE_W-1:0];
   assign res.hi  = hi_ff;
   assign res.lo  = lo_ff;

endmodule

/* rtl/core/twam_merge.sv */
`timescale 1ns / 1ps

module twam_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  twam_pkg::lane_res_type        res [twam_pkg::NUM_AXES],
   output logic                          load_ok,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [twam_pkg::RSP_W-1:0]    rsp_tdata
);
   import twam_pkg::*;

   logic             valid_ff;
   logic [RSP_W-1:0] data_ff;

   assign load_ok = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {res[2].lo, res[2].hi, res[1].lo, res[1].hi, res[0].lo, res[0].hi,
                     res[2].avg, res[1].avg, res[0].avg};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

/* rtl/core/three_axis_window_average_minmax.sv */
`timescale 1ns / 1ps

// Moving-window average, maximum and minimum of a three-axis sample stream.
// Each transfer on req carries one sample per axis; once the last L samples
// are stored (L = window length register, 0 read as 1, capped at WINDOW_MAX),
// every sample gives one transfer on rsp, otherwise none. A sample that gives
// no result keeps the input ready for the next sample. For a sample that gives
// a result, the window memory is scanned one entry per cycle through its single
// read port, then three per-axis serial dividers produce one quotient bit per
// cycle; the input is not ready until the result is handed to the output
// register. The output register lets the next sample in while a result waits.
// The window memory needs no clearing pass after reset.

module three_axis_window_average_minmax #(
   parameter int WINDOW_MAX = twam_pkg::WINDOW_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // sample_x, sample_y, sample_z
   input  logic [twam_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // avg_x, avg_y, avg_z, max_x, min_x, max_y, min_y, max_z, min_z
   output logic [twam_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_we,
   input  logic [twam_pkg::CFG_W-1:0] csr_wdata
);
   import twam_pkg::*;

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LW = $clog2(WINDOW_MAX + 1);
   localparam int CW = (LW > CFG_W) ? LW : CFG_W;
   localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);
   localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_MAX - 1);

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] window_length_ff;
   logic [LW-1:0]    fill_ff;
   logic [AW-1:0]    slot_ff;
   logic [LW-1:0]    len_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic [LW-1:0]    iss_cnt_ff;
   logic             rd_vld_ff;
   logic             rd_first_ff;
   logic             rd_last_ff;
   logic             div_start_ff;

   logic [REQ_W-1:0] mem [WINDOW_MAX];
   logic [REQ_W-1:0] mem_rdata_ff;

   logic             accept;
   logic             issue;
   logic [CW-1:0]    wl_ext;
   logic [CW-1:0]    len_cw;
   logic [LW-1:0]    len_eff;
   logic [LW-1:0]    fill_inc;
   logic             merge_load;
   logic             load_ok;
   logic [NUM_AXES-1:0] lane_busy;
   lane_ctl_type     lane_ctl;
   lane_res_type     lane_res [NUM_AXES];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue      = (state_ff == S_SCAN) && (iss_cnt_ff < len_ff);

   always_comb begin
      wl_ext = CW'(window_length_ff);
      if (wl_ext == '0) begin
         len_cw = CW'(1);
      end else if (wl_ext > WMAX_C) begin
         len_cw = WMAX_C;
      end else begin
         len_cw = wl_ext;
      end
      len_eff  = LW'(len_cw);
      fill_inc = (fill_ff < LW'(WINDOW_MAX)) ? fill_ff + LW'(1) : fill_ff;
   end

   always_comb begin
      state_in   = state_ff;
      merge_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (fill_inc >= len_eff)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_last_ff) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_start_ff && !(|lane_busy)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_ok) begin
               merge_load = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         window_length_ff <= WINDOW_LEN_RESET;
         fill_ff          <= '0;
         slot_ff          <= '0;
         iss_cnt_ff       <= '0;
         rd_vld_ff        <= 1'b0;
         rd_first_ff      <= 1'b0;
         rd_last_ff       <= 1'b0;
         div_start_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= issue;
         rd_first_ff  <= issue && (iss_cnt_ff == '0);
         rd_last_ff   <= issue && (iss_cnt_ff == len_ff - LW'(1));
         div_start_ff <= (state_ff == S_SCAN) && rd_last_ff;
         if (csr_we) begin
            window_length_ff <= csr_wdata;
         end
         if (accept) begin
            fill_ff    <= fill_inc;
            slot_ff    <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + AW'(1);
            iss_cnt_ff <= '0;
         end else if (issue) begin
            iss_cnt_ff <= iss_cnt_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         len_ff     <= len_eff;
         rd_addr_ff <= slot_ff;
      end else if (issue) begin
         rd_addr_ff <= (rd_addr_ff == '0) ? LAST_SLOT : rd_addr_ff - AW'(1);
      end
   end

   // window store, newest entry first on the scan
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[slot_ff] <= req_tdata;
      end
      mem_rdata_ff <= mem[rd_addr_ff];
   end

   assign lane_ctl.acc_valid = rd_vld_ff;
   assign lane_ctl.acc_first = rd_first_ff;
   assign lane_ctl.div_start = div_start_ff;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      twam_lane #(
         .LW (LW)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .sample (mem_rdata_ff[i*SAMPLE_W +: SAMPLE_W]),
         .len    (len_ff),
         .busy   (lane_busy[i]),
         .res    (lane_res[i])
      );
   end

   twam_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (merge_load),
      .res        (lane_res),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/core/twam_checker.sv */
`timescale 1ns / 1ps

module twam_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [twam_pkg::RSP_W-1:0] rsp_tdata
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   a_rst_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // a new result is only loaded while the input side is closed
   a_load_closed: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while input was open");

   // a result never follows its input transfer in the next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared right after an input transfer");

endmodule

bind three_axis_window_average_minmax twam_checker u_twam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
